@@ rtl/i2c_master_byte_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the I2C master byte sequencer checker
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define I2C_MBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define I2C_MBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/i2c_mbs_pkg.sv @@
// ----------------------------------------------------------------------------
// i2c_mbs_pkg
// Types, codes and the bus micro-program of the I2C master byte sequencer.
// ----------------------------------------------------------------------------
package i2c_mbs_pkg;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       reply_level;
    logic       scl_in;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       stretch_timeout;
  } out_item_t;

  // command codes
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_START   = 3'd1;
  localparam logic [2:0] MODE_WRITE   = 3'd2;
  localparam logic [2:0] MODE_RESTART = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;
  localparam logic [2:0] MODE_STOP    = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_PHASE_TICKS    = 2'd0;
  localparam logic [1:0] REG_STRETCH_LIMIT  = 2'd1;
  localparam logic [1:0] REG_ACK_POLL_LIMIT = 2'd2;

  localparam logic [15:0] PHASE_TICKS_RST    = 16'd5;
  localparam logic [13:0] STRETCH_LIMIT_RST  = 14'd10000;
  localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd100;

  // micro-program entry points
  localparam logic [4:0] PH_START   = 5'd0;
  localparam logic [4:0] PH_STOP    = 5'd3;
  localparam logic [4:0] PH_RESTART = 5'd7;
  localparam logic [4:0] PH_WRITE   = 5'd12;
  localparam logic [4:0] PH_READ    = 5'd22;
  localparam logic [4:0] PH_IDLE    = 5'd31;

  typedef enum logic [2:0] {
    DRV_LOW, DRV_HIGH, DRV_KEEP, DRV_BIT, DRV_REPLY
  } drv_t;

  typedef enum logic [2:0] {
    K_DELAY, K_WAIT, K_POLL, K_CHKTO, K_LOOPW, K_LOOPR, K_ACK, K_END
  } op_kind_t;

  typedef struct packed {
    drv_t       scl;
    drv_t       sda;
    op_kind_t   kind;
    logic [4:0] arg;
  } op_t;

  function automatic op_t prog_op(logic [4:0] p);
    op_t o;
    o = '{DRV_KEEP, DRV_KEEP, K_END, 5'd0};
    case (p)
      // start
      5'd0:  o = '{DRV_HIGH, DRV_HIGH, K_DELAY, 5'd1};
      5'd1:  o = '{DRV_KEEP, DRV_LOW,  K_DELAY, 5'd1};
      5'd2:  o = '{DRV_LOW,  DRV_KEEP, K_END,   5'd0};
      // stop
      5'd3:  o = '{DRV_LOW,  DRV_LOW,  K_DELAY, 5'd1};
      5'd4:  o = '{DRV_HIGH, DRV_KEEP, K_WAIT,  5'd0};
      5'd5:  o = '{DRV_KEEP, DRV_KEEP, K_DELAY, 5'd2};
      5'd6:  o = '{DRV_KEEP, DRV_HIGH, K_END,   5'd0};
      // restart
      5'd7:  o = '{DRV_KEEP, DRV_HIGH, K_DELAY, 5'd1};
      5'd8:  o = '{DRV_HIGH, DRV_KEEP, K_WAIT,  5'd0};
      5'd9:  o = '{DRV_KEEP, DRV_KEEP, K_DELAY, 5'd3};
      5'd10: o = '{DRV_KEEP, DRV_LOW,  K_DELAY, 5'd1};
      5'd11: o = '{DRV_LOW,  DRV_KEEP, K_END,   5'd0};
      // write byte
      5'd12: o = '{DRV_KEEP, DRV_BIT,  K_DELAY, 5'd2};
      5'd13: o = '{DRV_HIGH, DRV_KEEP, K_WAIT,  5'd0};
      5'd14: o = '{DRV_KEEP, DRV_KEEP, K_DELAY, 5'd1};
      5'd15: o = '{DRV_KEEP, DRV_KEEP, K_CHKTO, 5'd0};
      5'd16: o = '{DRV_LOW,  DRV_KEEP, K_LOOPW, PH_WRITE};
      5'd17: o = '{DRV_KEEP, DRV_HIGH, K_POLL,  5'd0};
      5'd18: o = '{DRV_HIGH, DRV_KEEP, K_ACK,   5'd0};
      5'd19: o = '{DRV_KEEP, DRV_KEEP, K_DELAY, 5'd1};
      5'd20: o = '{DRV_LOW,  DRV_KEEP, K_DELAY, 5'd1};
      5'd21: o = '{DRV_KEEP, DRV_KEEP, K_END,   5'd0};
      // read byte
      5'd22: o = '{DRV_KEEP, DRV_HIGH,  K_DELAY, 5'd2};
      5'd23: o = '{DRV_HIGH, DRV_KEEP,  K_WAIT,  5'd0};
      5'd24: o = '{DRV_KEEP, DRV_KEEP,  K_DELAY, 5'd1};
      5'd25: o = '{DRV_KEEP, DRV_KEEP,  K_CHKTO, 5'd1};
      5'd26: o = '{DRV_LOW,  DRV_KEEP,  K_LOOPR, PH_READ};
      5'd27: o = '{DRV_KEEP, DRV_REPLY, K_DELAY, 5'd1};
      5'd28: o = '{DRV_HIGH, DRV_KEEP,  K_DELAY, 5'd1};
      5'd29: o = '{DRV_LOW,  DRV_KEEP,  K_END,   5'd1};
      default: o = '{DRV_KEEP, DRV_KEEP, K_END, 5'd0};
    endcase
    return o;
  endfunction

  function automatic logic [4:0] entry_phase(logic [2:0] mode);
    logic [4:0] p;
    p = PH_START;
    case (mode)
      MODE_WRITE:   p = PH_WRITE;
      MODE_RESTART: p = PH_RESTART;
      MODE_READ:    p = PH_READ;
      MODE_STOP:    p = PH_STOP;
      default:      p = PH_START;
    endcase
    return p;
  endfunction

  function automatic logic drv_level(drv_t code, logic cur, logic msb, logic rep);
    logic v;
    v = cur;
    case (code)
      DRV_LOW:   v = 1'b0;
      DRV_HIGH:  v = 1'b1;
      DRV_KEEP:  v = cur;
      DRV_BIT:   v = msb;
      DRV_REPLY: v = rep;
      default:   v = cur;
    endcase
    return v;
  endfunction

  // line drive after entering an op: bit 1 SDA, bit 0 SCL
  function automatic logic [1:0] op_drive(op_t o, logic [1:0] cur, logic msb, logic rep);
    return {drv_level(o.sda, cur[1], msb, rep), drv_level(o.scl, cur[0], msb, rep)};
  endfunction

endpackage

@@ rtl/i2c_master_byte_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// Open-drain I2C master stepped once per tick: start, write, restart, read, stop.
// ----------------------------------------------------------------------------
//  channel   signals                          payload
//  in        in_valid / in_stall / in_item    one bus tick, optional command
//  out       out_valid / out_stall / out_item line drive and status per tick
//  cfg       cfg_write / cfg_index / cfg_data phase, stretch and ack poll limits
//
//  One tick per cycle unless a held result stalls the input; a tick's result shows the cycle after its transfer.
//  The state registers are the result register; in_stall follows a held result.
//  Reset (rst, synchronous): idle, both lines released, registers at defaults.
//  A stalled result stays on out_item until it transfers.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer
  import i2c_mbs_pkg::*;
#(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

  logic [15:0] phase_ticks;
  logic [13:0] stretch_limit;
  logic [7:0]  ack_poll_limit;

  logic [4:0]                  phase, phase_next;
  logic [3:0]                  bit_count, bit_count_next;
  logic [7:0]                  shift_reg, shift_reg_next;
  logic [TICK_COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [13:0]                 wait_count, wait_count_next;
  logic [1:0]                  line_drive, line_drive_next;   // bit1 SDA, bit0 SCL
  logic [1:0]                  status_bits, status_bits_next; // bit1 timeout, bit0 ack
  logic [7:0]                  rx_hold, rx_hold_next;
  logic                        reply_hold, reply_hold_next;
  logic                        done, done_next;

  logic                        accept;
  logic [TICK_COUNT_WIDTH-1:0] tick_inc;
  logic                        reached;
  logic [14:0]                 wc_inc;
  logic                        go;
  logic                        run_chain;
  op_t                         op, cop;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign tick_inc = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign reached  = (CW'(tick_inc) >= CW'(phase_ticks)) || (tick_inc == '1);
  assign wc_inc   = {1'b0, wait_count} + 15'd1;

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    tick_count_next  = tick_count;
    wait_count_next  = wait_count;
    line_drive_next  = line_drive;
    status_bits_next = status_bits;
    rx_hold_next     = rx_hold;
    reply_hold_next  = reply_hold;
    done_next        = 1'b0;
    go               = 1'b0;
    run_chain        = 1'b0;
    op               = prog_op(phase);
    cop              = op;

    if (phase == PH_IDLE) begin
      if (in_item.mode >= MODE_START && in_item.mode <= MODE_STOP) begin
        status_bits_next[1] = 1'b0;
        bit_count_next      = '0;
        if (in_item.mode == MODE_WRITE) begin
          shift_reg_next   = in_item.tx_byte;
          status_bits_next = '0;
        end else if (in_item.mode == MODE_READ) begin
          shift_reg_next  = '0;
          reply_hold_next = in_item.reply_level;
        end
        phase_next      = entry_phase(in_item.mode);
        tick_count_next = '0;
        wait_count_next = '0;
        line_drive_next = op_drive(prog_op(phase_next), line_drive_next,
                                   shift_reg_next[7], reply_hold_next);
        run_chain       = 1'b1;
      end
    end else if (!reached) begin
      tick_count_next = tick_inc;
    end else begin
      tick_count_next = '0;
      case (op.kind)
        K_DELAY: begin
          wait_count_next = wc_inc[13:0];
          go = wc_inc >= 15'(op.arg);
        end
        K_WAIT: begin
          if (in_item.scl_in) begin
            go = 1'b1;
          end else begin
            wait_count_next = wc_inc[13:0];
            if (wc_inc >= 15'(stretch_limit)) begin
              status_bits_next[1] = 1'b1;
              go = 1'b1;
            end
          end
        end
        K_POLL: begin
          if (!in_item.sda_in) begin
            go = 1'b1;
          end else begin
            wait_count_next = wc_inc[13:0];
            go = wc_inc >= 15'(ack_poll_limit);
          end
        end
        default: go = 1'b0;
      endcase
      if (go) begin
        phase_next      = phase + 5'd1;
        tick_count_next = '0;
        wait_count_next = '0;
        line_drive_next = op_drive(prog_op(phase_next), line_drive_next,
                                   shift_reg_next[7], reply_hold_next);
        run_chain       = 1'b1;
      end
    end

    // zero-time ops: at most a check and a bit step before a timed op
    for (int s = 0; s < 3; s++) begin
      if (run_chain && phase_next != PH_IDLE) begin
        cop = prog_op(phase_next);
        case (cop.kind)
          K_CHKTO: begin
            if (status_bits_next[1]) begin
              if (cop.arg[0]) rx_hold_next = '0;
              phase_next = PH_IDLE;
              done_next  = 1'b1;
              run_chain  = 1'b0;
            end else begin
              phase_next = phase_next + 5'd1;
            end
          end
          K_LOOPW, K_LOOPR: begin
            shift_reg_next = {shift_reg_next[6:0],
                              (cop.kind == K_LOOPR) ? in_item.sda_in : 1'b0};
            bit_count_next = bit_count_next + 4'd1;
            phase_next     = (bit_count_next < 4'd8) ? cop.arg : phase_next + 5'd1;
          end
          K_ACK: begin
            status_bits_next[0] = ~in_item.sda_in;
            phase_next          = phase_next + 5'd1;
          end
          K_END: begin
            if (cop.arg[0]) rx_hold_next = shift_reg_next;
            phase_next = PH_IDLE;
            done_next  = 1'b1;
            run_chain  = 1'b0;
          end
          default: run_chain = 1'b0;
        endcase
        if (run_chain) begin
          line_drive_next = op_drive(prog_op(phase_next), line_drive_next,
                                     shift_reg_next[7], reply_hold_next);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks    <= PHASE_TICKS_RST;
      stretch_limit  <= STRETCH_LIMIT_RST;
      ack_poll_limit <= ACK_POLL_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PHASE_TICKS:    phase_ticks    <= cfg_data;
        REG_STRETCH_LIMIT:  stretch_limit  <= cfg_data[13:0];
        REG_ACK_POLL_LIMIT: ack_poll_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      shift_reg   <= '0;
      tick_count  <= '0;
      wait_count  <= '0;
      line_drive  <= 2'b11;
      status_bits <= '0;
      rx_hold     <= '0;
      reply_hold  <= 1'b0;
      done        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        bit_count   <= bit_count_next;
        shift_reg   <= shift_reg_next;
        tick_count  <= tick_count_next;
        wait_count  <= wait_count_next;
        line_drive  <= line_drive_next;
        status_bits <= status_bits_next;
        rx_hold     <= rx_hold_next;
        reply_hold  <= reply_hold_next;
        done        <= done_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_item.scl_release     = line_drive[0];
  assign out_item.sda_release     = line_drive[1];
  assign out_item.busy_res        = (phase != PH_IDLE);
  assign out_item.done_res        = done;
  assign out_item.rx_byte         = rx_hold;
  assign out_item.ack_seen        = status_bits[0];
  assign out_item.stretch_timeout = status_bits[1];

endmodule

@@ rtl/i2c_mbs_checker.sv @@
// ----------------------------------------------------------------------------
// i2c_mbs_checker
// Port-level checks on the I2C master byte sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_sequencer_defines.svh"

module i2c_mbs_checker
  import i2c_mbs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // a held result must stay put
  `I2C_MBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")

  // every tick transfer yields a result on the next cycle
  `I2C_MBS_ASSERT_NEXT(a_tick_result, in_valid && !in_stall, out_valid, "tick transfer without result")

  // input only backs up behind a held result
  `I2C_MBS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with no held result")

  // a finishing command is no longer busy
  `I2C_MBS_ASSERT_NOW(a_done_idle, out_valid && out_item.done_res, !out_item.busy_res, "done while still busy")

endmodule

bind i2c_master_byte_sequencer i2c_mbs_checker u_i2c_mbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
